>>> rtl/core/tha_pkg.sv
// Shared types and constants of the turn/hazard lamp arbiter and flasher.
`default_nettype none

package tha_pkg;

    // Lamp codes, also the bit positions of the drive word.
    localparam logic [2:0] LAMP_LEFT   = 3'd0;
    localparam logic [2:0] LAMP_RIGHT  = 3'd1;
    localparam logic [2:0] LAMP_HAZARD = 3'd2;
    localparam logic [2:0] LAMP_PARK   = 3'd3;
    localparam logic [2:0] LAMP_HEAD   = 3'd4;

    localparam logic [1:0] ACT_ON     = 2'd0;
    localparam logic [1:0] ACT_OFF    = 2'd1;
    localparam logic [1:0] ACT_TOGGLE = 2'd2;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic OP_LAMP = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_DRIVE  = 1'b1;

    localparam logic [1:0] REM_NONE  = 2'd0;
    localparam logic [1:0] REM_LEFT  = 2'd1;
    localparam logic [1:0] REM_RIGHT = 2'd2;

    localparam logic CFG_BLINK_ON  = 1'b0;
    localparam logic CFG_BLINK_OFF = 1'b1;

    localparam logic [15:0] BLINK_MS_RESET = 16'd500;

    localparam int MAX_RESULTS = 4;

    typedef struct packed {
        logic        opcode;
        logic [2:0]  lamp_select;
        logic [1:0]  lamp_action;
        logic [15:0] sequence_number;
        logic [31:0] time_now_ms;
    } t_in_word;

    typedef struct packed {
        logic       result_kind;
        logic [2:0] event_lamp;
        logic       event_lamp_on;
        logic [4:0] drive_bits;
        logic       last_result;
    } t_out_word;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_HAZARD,
        CMD_IND,
        CMD_PLAIN
    } t_cmd_kind;

    // Classified command handed from the front to the back.
    typedef struct packed {
        t_cmd_kind   kind;
        logic [2:0]  lamp;
        logic [1:0]  act;
        logic [15:0] seq;
        logic [31:0] now;
    } t_cmd;

endpackage

`default_nettype wire

>>> rtl/core/tha_front.sv
// Input register and command classifier of the lamp arbiter.
`default_nettype none

module tha_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire tha_pkg::t_in_word i_word,
    output logic                   o_stall,
    output logic                   o_push,
    output tha_pkg::t_cmd          o_cmd,
    input  wire logic              i_full
);
    import tha_pkg::*;

    logic   r_valid;
    t_cmd   r_cmd;
    t_cmd   n_cmd;
    logic   n_keep;
    logic   take;

    assign o_push  = r_valid && !i_full;
    assign o_stall = r_valid && i_full;
    assign o_cmd   = r_cmd;
    assign take    = i_valid && !o_stall;

    // Classify; drop unknown selectors, and undefined actions on indicator and plain lamps, right here.
    always_comb begin
        n_cmd.lamp = i_word.lamp_select;
        n_cmd.act  = i_word.lamp_action;
        n_cmd.seq  = i_word.sequence_number;
        n_cmd.now  = i_word.time_now_ms;
        n_cmd.kind = CMD_TICK;
        n_keep     = 1'b0;
        if (i_word.opcode == OP_TICK) begin
            n_keep = 1'b1;
        end else if (i_word.lamp_select == LAMP_HAZARD) begin
            n_cmd.kind = CMD_HAZARD;
            n_keep     = 1'b1;
        end else if (i_word.lamp_select == LAMP_LEFT || i_word.lamp_select == LAMP_RIGHT) begin
            n_cmd.kind = CMD_IND;
            n_keep     = i_word.lamp_action != ACT_UNUSED;
        end else if (i_word.lamp_select == LAMP_PARK || i_word.lamp_select == LAMP_HEAD) begin
            n_cmd.kind = CMD_PLAIN;
            n_keep     = i_word.lamp_action != ACT_UNUSED;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || o_push) begin
            r_valid <= take && n_keep;
        end
        if (!r_valid || o_push) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tha_queue.sv
// Short command queue between the front and the back of the lamp arbiter.
`default_nettype none

module tha_queue #(
    parameter int P_DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tha_pkg::t_cmd i_cmd,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output tha_pkg::t_cmd      o_cmd
);
    import tha_pkg::*;

    localparam int PW = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CW = $clog2(P_DEPTH + 1);

    t_cmd          r_mem [P_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
        if (p == PW'(P_DEPTH - 1)) begin
            return '0;
        end
        return p + PW'(1);
    endfunction

    assign o_full  = r_cnt == CW'(P_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= ptr_next(r_wr);
            end
            if (do_pop) begin
                r_rd <= ptr_next(r_rd);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/tha_back.sv
// Lamp state, blink timers and result sequencing of the lamp arbiter.
`default_nettype none

module tha_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               i_q_valid,
    input  wire tha_pkg::t_cmd      i_q_cmd,
    output logic                    o_q_pop,
    output logic                    o_valid,
    output tha_pkg::t_out_word      o_word,
    input  wire logic               i_stall
);
    import tha_pkg::*;

    localparam int RW = $clog2(MAX_RESULTS + 1);
    localparam int IW = $clog2(MAX_RESULTS);

    typedef struct packed {
        logic        active;
        logic        phase;
        logic [31:0] start;
    } t_blink;

    logic [4:0]  r_lamp;
    logic [4:0]  n_lamp;
    logic [15:0] r_haz_seq;
    logic [15:0] n_haz_seq;
    logic [1:0]  r_rem;
    logic [1:0]  n_rem;
    t_blink      r_blink [3];
    t_blink      n_blink [3];
    logic [15:0] r_on_ms;
    logic [15:0] r_off_ms;

    t_out_word   r_res [MAX_RESULTS];
    t_out_word   n_res [MAX_RESULTS];
    logic [RW-1:0] r_left;
    logic [RW-1:0] n_cnt;
    logic [IW-1:0] r_idx;

    logic        take;
    logic        buf_free;
    logic [4:0]  drive;
    logic        ind;
    logic        eff_on;
    logic [IW-1:0] slot;

    function automatic t_out_word status(input logic [2:0] lamp, input logic on);
        t_out_word w;
        w               = '0;
        w.result_kind   = KIND_STATUS;
        w.event_lamp    = lamp;
        w.event_lamp_on = on;
        return w;
    endfunction

    // Start a stopped timer lit; flip the phase once its length has run out.
    function automatic t_blink blink_step(input t_blink b, input logic [31:0] now,
                                          input logic [15:0] on_ms,
                                          input logic [15:0] off_ms);
        t_blink      nb;
        logic [31:0] period;
        nb     = b;
        period = {16'd0, (b.phase ? on_ms : off_ms)};
        if (!b.active) begin
            nb.active = 1'b1;
            nb.phase  = 1'b1;
            nb.start  = now;
        end else if ((now - b.start) >= period) begin
            nb.phase = !b.phase;
            nb.start = now;
        end
        return nb;
    endfunction

    assign o_valid  = r_left != '0;
    assign o_word   = r_res[r_idx];
    assign take     = o_valid && !i_stall;
    assign buf_free = (r_left == '0) || (r_left == RW'(1) && take);
    assign o_q_pop  = i_q_valid && buf_free;

    always_comb begin
        n_lamp    = r_lamp;
        n_haz_seq = r_haz_seq;
        n_rem     = r_rem;
        n_blink   = r_blink;
        n_cnt     = '0;
        drive     = '0;
        slot      = '0;
        ind       = i_q_cmd.lamp[0];
        eff_on    = 1'b0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            n_res[k] = '0;
        end
        if (o_q_pop) begin
            unique case (i_q_cmd.kind)
                CMD_TICK: begin
                    if (r_lamp[LAMP_HAZARD]) begin
                        n_blink[2] = blink_step(r_blink[2], i_q_cmd.now, r_on_ms, r_off_ms);
                        drive[2:0] = {3{n_blink[2].phase}};
                    end else begin
                        n_blink[2] = '0;
                        for (int i = 0; i < 2; i++) begin
                            if (r_lamp[i]) begin
                                n_blink[i] = blink_step(r_blink[i], i_q_cmd.now,
                                                        r_on_ms, r_off_ms);
                                drive[i]   = n_blink[i].phase;
                            end else begin
                                n_blink[i] = '0;
                            end
                        end
                    end
                    drive[4:3]           = r_lamp[4:3];
                    n_res[0].result_kind = KIND_DRIVE;
                    n_res[0].drive_bits  = drive;
                    n_cnt                = RW'(1);
                end
                CMD_HAZARD: begin
                    n_haz_seq = i_q_cmd.seq;
                    if (r_lamp[LAMP_HAZARD]) begin
                        // Hazard off: clear all three, then restore the remembered one.
                        n_lamp[2:0] = 3'b000;
                        n_res[0]    = status(LAMP_HAZARD, 1'b0);
                        n_res[1]    = status(LAMP_LEFT, 1'b0);
                        n_res[2]    = status(LAMP_RIGHT, 1'b0);
                        n_cnt       = RW'(3);
                        if (r_rem == REM_LEFT) begin
                            n_lamp[LAMP_LEFT] = 1'b1;
                            n_res[3]          = status(LAMP_LEFT, 1'b1);
                            n_cnt             = RW'(4);
                        end else if (r_rem == REM_RIGHT) begin
                            n_lamp[LAMP_RIGHT] = 1'b1;
                            n_res[3]           = status(LAMP_RIGHT, 1'b1);
                            n_cnt              = RW'(4);
                        end
                        n_rem = REM_NONE;
                    end else begin
                        n_lamp[LAMP_HAZARD] = 1'b1;
                        if (r_lamp[LAMP_LEFT]) begin
                            n_rem = REM_LEFT;
                        end else if (r_lamp[LAMP_RIGHT]) begin
                            n_rem = REM_RIGHT;
                        end else begin
                            n_rem = REM_NONE;
                        end
                        n_res[0] = status(LAMP_HAZARD, 1'b1);
                        n_cnt    = RW'(1);
                    end
                end
                CMD_IND: begin
                    // Drop on a repeated hazard sequence or while hazard is lit.
                    if (i_q_cmd.seq != r_haz_seq && !r_lamp[LAMP_HAZARD]) begin
                        eff_on = (i_q_cmd.act == ACT_ON) ||
                                 (i_q_cmd.act == ACT_TOGGLE && !r_lamp[ind]);
                        if (eff_on) begin
                            n_rem = ind ? REM_RIGHT : REM_LEFT;
                            if (r_lamp[!ind]) begin
                                n_lamp[!ind] = 1'b0;
                                n_res[0]     = status({2'b00, !ind}, 1'b0);
                                slot         = IW'(1);
                            end
                            n_lamp[ind] = 1'b1;
                            n_res[slot] = status({2'b00, ind}, 1'b1);
                            n_cnt       = RW'(slot) + RW'(1);
                        end else begin
                            if (r_rem == (ind ? REM_RIGHT : REM_LEFT)) begin
                                n_rem = REM_NONE;
                            end
                            n_lamp[ind] = 1'b0;
                            n_res[0]    = status({2'b00, ind}, 1'b0);
                            n_cnt       = RW'(1);
                        end
                    end
                end
                CMD_PLAIN: begin
                    eff_on = (i_q_cmd.act == ACT_TOGGLE) ? !r_lamp[i_q_cmd.lamp]
                                                         : (i_q_cmd.act == ACT_ON);
                    n_lamp[i_q_cmd.lamp] = eff_on;
                    n_res[0]             = status(i_q_cmd.lamp, eff_on);
                    n_cnt                = RW'(1);
                end
                default: begin
                end
            endcase
        end
        // Mark the final word of this command.
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (RW'(k) + RW'(1) == n_cnt) begin
                n_res[k].last_result = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lamp    <= '0;
            r_haz_seq <= '0;
            r_rem     <= REM_NONE;
            r_blink   <= '{default: '0};
            r_on_ms   <= BLINK_MS_RESET;
            r_off_ms  <= BLINK_MS_RESET;
            r_left    <= '0;
            r_idx     <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_BLINK_ON) begin
                    r_on_ms <= i_cfg_data;
                end else begin
                    r_off_ms <= i_cfg_data;
                end
            end
            r_lamp    <= n_lamp;
            r_haz_seq <= n_haz_seq;
            r_rem     <= n_rem;
            r_blink   <= n_blink;
            if (o_q_pop) begin
                r_left <= n_cnt;
                r_idx  <= '0;
            end else if (take) begin
                r_left <= r_left - RW'(1);
                r_idx  <= r_idx + IW'(1);
            end
        end
        if (o_q_pop) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/turn_hazard_lamp_arbiter_flasher.sv
// Top level of the turn/hazard lamp arbiter and flasher.
//
// Input channel (i_valid, i_word, o_stall): one word is either a lamp
// command (left, right, hazard, park, head) or a millisecond timer tick.
// Output channel (o_valid, o_word, i_stall): status events for every lamp
// change, and one five-bit drive word per tick.
// Config port (i_cfg_we, i_cfg_index, i_cfg_data): index 0 sets the lit
// blink phase length, index 1 the dark phase length, both in ms.
//
// A command's input word passes the input register, the command queue and
// the result buffer before its first result word can leave. Then one result
// word leaves per cycle unless the receiver stalls: a tick yields one word, a
// command none to four (four for hazard off with a remembered indicator). The
// result buffer sets that pace and loads the next command as its last word goes.
// Front and back are split by a short command queue, so new words keep
// coming in while results wait on a stalled receiver; once queue and input
// register are full, o_stall rises.
// Reset (synchronous, active low) turns all lamps off, stops all blink
// timers, clears the hazard sequence and returns both phase lengths to 500.
`default_nettype none

module turn_hazard_lamp_arbiter_flasher #(
    parameter int P_QUEUE_DEPTH = 2
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire tha_pkg::t_in_word  i_word,
    output logic                    o_stall,
    output logic                    o_valid,
    output tha_pkg::t_out_word      o_word,
    input  wire logic               i_stall,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_index,
    input  wire logic [15:0]        i_cfg_data
);
    import tha_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic q_valid;
    t_cmd front_cmd;
    t_cmd q_cmd;

    // Front: register and classify incoming words, drop unusable ones.
    tha_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_word  (i_word),
        .o_stall (o_stall),
        .o_push  (push),
        .o_cmd   (front_cmd),
        .i_full  (full)
    );

    // Decouple the two sides.
    tha_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Back: apply commands to lamp state, advance blink timers, emit results.
    tha_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (pop),
        .o_valid     (o_valid),
        .o_word      (o_word),
        .i_stall     (i_stall)
    );

endmodule

`default_nettype wire
